// File: hdl/sm83alu_pkg.sv
// Shared types of the SM83 ALU: operation codes and request/response records.
package sm83alu_pkg;

	localparam int unsigned CMD_W  = 5;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned WORD_W = 16;
	localparam int unsigned BIT_W  = 3;

	typedef enum logic [CMD_W-1:0] {
		CMD_INC    = 5'd0,
		CMD_DEC    = 5'd1,
		CMD_ADD    = 5'd2,
		CMD_ADC    = 5'd3,
		CMD_SUB    = 5'd4,
		CMD_SBC    = 5'd5,
		CMD_AND    = 5'd6,
		CMD_XOR    = 5'd7,
		CMD_OR     = 5'd8,
		CMD_RLC    = 5'd9,
		CMD_RRC    = 5'd10,
		CMD_RL     = 5'd11,
		CMD_RR     = 5'd12,
		CMD_SLA    = 5'd13,
		CMD_SRA    = 5'd14,
		CMD_SRL    = 5'd15,
		CMD_SWAP   = 5'd16,
		CMD_BIT    = 5'd17,
		CMD_ADD_HL = 5'd18,
		CMD_ADD_SP = 5'd19
	} cmd_t;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [BYTE_W-1:0] acc;
		logic [WORD_W-1:0] operand;
		logic [WORD_W-1:0] base_word;
		logic [BIT_W-1:0]  bit_index;
		logic              zero_in;
		logic              carry_in;
	} req_t;

	typedef struct packed {
		logic [WORD_W-1:0] result;
		logic              zero_out;
		logic              subtract_out;
		logic              half_carry_out;
		logic              carry_out;
	} rsp_t;

endpackage

// File: hdl/sm83alu_req_if.sv
// Request channel of the SM83 ALU: valid/ready handshake and operation fields.
interface sm83alu_req_if;
	import sm83alu_pkg::*;

	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [BYTE_W-1:0] acc;
	logic [WORD_W-1:0] operand;
	logic [WORD_W-1:0] base_word;
	logic [BIT_W-1:0]  bit_index;
	logic              zero_in;
	logic              carry_in;

	modport source (
		output valid, command, acc, operand, base_word, bit_index, zero_in, carry_in,
		input  ready
	);

	modport sink (
		input  valid, command, acc, operand, base_word, bit_index, zero_in, carry_in,
		output ready
	);

endinterface

// File: hdl/sm83alu_rsp_if.sv
// Response channel of the SM83 ALU: valid/ready handshake, result and flags.
interface sm83alu_rsp_if;
	import sm83alu_pkg::*;

	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] result;
	logic              zero_out;
	logic              subtract_out;
	logic              half_carry_out;
	logic              carry_out;

	modport source (
		output valid, result, zero_out, subtract_out, half_carry_out, carry_out,
		input  ready
	);

	modport sink (
		input  valid, result, zero_out, subtract_out, half_carry_out, carry_out,
		output ready
	);

endinterface

// File: hdl/sm83_alu_with_flags.sv
// SM83 ALU: registered request, one pass of flag/result logic, registered response.
//
// Usage:
//   req carries one ALU request: operation code, accumulator, operand, base word
//   (HL or SP), bit index and the incoming Z and C flags. rsp returns the 16-bit
//   result and the flags Z, N, H and C. Both channels move a request on a rising
//   edge of clk where valid and ready are both high.
//   An accepted request passes the input register and then the result register
//   before it shows on rsp. Throughput: one request per cycle, sustained, as long
//   as rsp.ready stays high.
//   The operation logic sits between the two registers: adders of up to 17 bits with
//   their carry taps and the selection of the result by operation code.
//   Stall: when rsp.ready is low the response holds; the input register still
//   takes one more request, and req.ready falls only once both stages are full.
//   Reset (arst_n low) empties both stages at once; rsp.valid drops and the
//   block accepts a request in the first cycle after reset is released.
module sm83_alu_with_flags (
	input logic          clk,
	input logic          arst_n,
	sm83alu_req_if.sink  req,
	sm83alu_rsp_if.source rsp
);
	import sm83alu_pkg::*;

	logic valid_s1;
	logic valid_s2;
	req_t req_s1;
	rsp_t rsp_s2;
	rsp_t rsp_d;
	logic load_s2;
	logic load_s1;

	// Advance the stages: the result stage frees when empty or when taken
	assign load_s2   = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || load_s2;
	assign load_s1   = req.valid && req.ready;

	// Hold the valid bits of both stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (!valid_s2 || rsp.ready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Capture the request fields
	always_ff @(posedge clk) begin
		if (load_s1) begin
			req_s1.command   <= req.command;
			req_s1.acc       <= req.acc;
			req_s1.operand   <= req.operand;
			req_s1.base_word <= req.base_word;
			req_s1.bit_index <= req.bit_index;
			req_s1.zero_in   <= req.zero_in;
			req_s1.carry_in  <= req.carry_in;
		end
	end

	// Compute the result and flags of the registered request
	always_comb begin
		logic [BYTE_W-1:0] a;
		logic [BYTE_W-1:0] v;
		logic              t;
		logic [BYTE_W-1:0] r8;
		logic [BYTE_W:0]   sum9;
		logic [4:0]        nib5;
		logic [WORD_W:0]   sum17;
		logic [12:0]       sum13;
		logic [WORD_W-1:0] sext;

		a     = req_s1.acc;
		v     = req_s1.operand[BYTE_W-1:0];
		t     = 1'b0;
		r8    = '0;
		sum9  = '0;
		nib5  = '0;
		sum17 = '0;
		sum13 = '0;
		sext  = {{BYTE_W{v[BYTE_W-1]}}, v};

		rsp_d.result         = '0;
		rsp_d.zero_out       = req_s1.zero_in;
		rsp_d.subtract_out   = 1'b0;
		rsp_d.half_carry_out = 1'b0;
		rsp_d.carry_out      = req_s1.carry_in;

		unique case (cmd_t'(req_s1.command))
			CMD_INC: begin
				r8 = v + 8'd1;
				rsp_d.half_carry_out = (v[3:0] == 4'hF);
			end
			CMD_DEC: begin
				r8 = v - 8'd1;
				rsp_d.subtract_out   = 1'b1;
				rsp_d.half_carry_out = (v[3:0] == 4'h0);
			end
			CMD_ADD, CMD_ADC: begin
				t    = (req_s1.command == CMD_ADC) ? req_s1.carry_in : 1'b0;
				sum9 = {1'b0, a} + {1'b0, v} + {8'd0, t};
				nib5 = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, t};
				r8   = sum9[BYTE_W-1:0];
				rsp_d.half_carry_out = nib5[4];
				rsp_d.carry_out      = sum9[BYTE_W];
			end
			CMD_SUB, CMD_SBC: begin
				t    = (req_s1.command == CMD_SBC) ? req_s1.carry_in : 1'b0;
				sum9 = {1'b0, a} - {1'b0, v} - {8'd0, t};
				nib5 = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, t};
				r8   = sum9[BYTE_W-1:0];
				rsp_d.subtract_out   = 1'b1;
				rsp_d.half_carry_out = nib5[4];
				rsp_d.carry_out      = sum9[BYTE_W];
			end
			CMD_AND: begin
				r8 = a & v;
				rsp_d.half_carry_out = 1'b1;
				rsp_d.carry_out      = 1'b0;
			end
			CMD_XOR: begin
				r8 = a ^ v;
				rsp_d.carry_out = 1'b0;
			end
			CMD_OR: begin
				r8 = a | v;
				rsp_d.carry_out = 1'b0;
			end
			CMD_RLC: begin
				r8 = {v[6:0], v[7]};
				rsp_d.carry_out = v[7];
			end
			CMD_RRC: begin
				r8 = {v[0], v[7:1]};
				rsp_d.carry_out = v[0];
			end
			CMD_RL: begin
				r8 = {v[6:0], req_s1.carry_in};
				rsp_d.carry_out = v[7];
			end
			CMD_RR: begin
				r8 = {req_s1.carry_in, v[7:1]};
				rsp_d.carry_out = v[0];
			end
			CMD_SLA: begin
				r8 = {v[6:0], 1'b0};
				rsp_d.carry_out = v[7];
			end
			CMD_SRA: begin
				r8 = {v[7], v[7:1]};
				rsp_d.carry_out = v[0];
			end
			CMD_SRL: begin
				r8 = {1'b0, v[7:1]};
				rsp_d.carry_out = v[0];
			end
			CMD_SWAP: begin
				r8 = {v[3:0], v[7:4]};
				rsp_d.carry_out = 1'b0;
			end
			CMD_BIT: begin
				rsp_d.zero_out       = !v[req_s1.bit_index];
				rsp_d.half_carry_out = 1'b1;
			end
			CMD_ADD_HL: begin
				sum17 = {1'b0, req_s1.base_word} + {1'b0, req_s1.operand};
				sum13 = {1'b0, req_s1.base_word[11:0]} + {1'b0, req_s1.operand[11:0]};
				rsp_d.result         = sum17[WORD_W-1:0];
				rsp_d.half_carry_out = sum13[12];
				rsp_d.carry_out      = sum17[WORD_W];
			end
			CMD_ADD_SP: begin
				sum17 = {1'b0, req_s1.base_word} + {1'b0, sext};
				sum9  = {1'b0, req_s1.base_word[BYTE_W-1:0]} + {1'b0, v};
				nib5  = {1'b0, req_s1.base_word[3:0]} + {1'b0, v[3:0]};
				rsp_d.result         = sum17[WORD_W-1:0];
				rsp_d.zero_out       = 1'b0;
				rsp_d.half_carry_out = nib5[4];
				rsp_d.carry_out      = sum9[BYTE_W];
			end
			default: begin
				r8 = '0;
			end
		endcase

		// Place byte results in the low half and set Z from them
		if (req_s1.command <= CMD_SWAP) begin
			rsp_d.result   = {8'h00, r8};
			rsp_d.zero_out = (r8 == 8'h00);
		end
	end

	// Register the response
	always_ff @(posedge clk) begin
		if (load_s2) begin
			rsp_s2 <= rsp_d;
		end
	end

	assign rsp.valid          = valid_s2;
	assign rsp.result         = rsp_s2.result;
	assign rsp.zero_out       = rsp_s2.zero_out;
	assign rsp.subtract_out   = rsp_s2.subtract_out;
	assign rsp.half_carry_out = rsp_s2.half_carry_out;
	assign rsp.carry_out      = rsp_s2.carry_out;

endmodule

// File: hdl/sm83alu_checker.sv
// Port-level checks of the SM83 ALU and their binding to the top level.
module sm83alu_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic [sm83alu_pkg::WORD_W-1:0] rsp_result
);

	// An empty result stage always lets a request in
	a_idle_accepts: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
		else $error("request refused while no response is pending");

	// An accepted request reaches the output through both stages while the receiver is ready
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) ##1 rsp_ready |=> rsp_valid)
		else $error("accepted request did not reach the response port");

	// Hold a stalled response
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("stalled response dropped");

	// Keep a stalled result unchanged
	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_result))
		else $error("stalled result changed");

endmodule

bind sm83_alu_with_flags sm83alu_checker u_sm83alu_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_result (rsp.result)
);
